>>> design/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMP(name, clk, rst_n, cond, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(name, clk, rst_n, cond, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> design/gcs_pkg.sv
package gcs_pkg;

    localparam int CP_W       = 21;
    localparam int SCALE_FRAC = 8;
    localparam int TERM_W     = 41;
    localparam int FIFO_DEPTH = 4;
    localparam int INDEX_BITS = 16;

    localparam logic [15:0] SCALE_RESET = 16'd256;

    localparam logic [7:0]      ASCII_LIMIT  = 8'h80;
    localparam logic [CP_W-1:0] CP_ZWJ       = 21'h0200D;
    localparam logic [CP_W-1:0] CP_COMB_A_LO = 21'h00300;
    localparam logic [CP_W-1:0] CP_COMB_A_HI = 21'h0036F;
    localparam logic [CP_W-1:0] CP_COMB_B_LO = 21'h01AB0;
    localparam logic [CP_W-1:0] CP_COMB_B_HI = 21'h01AFF;
    localparam logic [CP_W-1:0] CP_COMB_C_LO = 21'h01DC0;
    localparam logic [CP_W-1:0] CP_COMB_C_HI = 21'h01DFF;
    localparam logic [CP_W-1:0] CP_COMB_D_LO = 21'h020D0;
    localparam logic [CP_W-1:0] CP_COMB_D_HI = 21'h020FF;
    localparam logic [CP_W-1:0] CP_COMB_E_LO = 21'h0FE20;
    localparam logic [CP_W-1:0] CP_COMB_E_HI = 21'h0FE2F;
    localparam logic [CP_W-1:0] CP_VS_A_LO   = 21'h0FE00;
    localparam logic [CP_W-1:0] CP_VS_A_HI   = 21'h0FE0F;
    localparam logic [CP_W-1:0] CP_VS_B_LO   = 21'hE0100;
    localparam logic [CP_W-1:0] CP_VS_B_HI   = 21'hE01EF;
    localparam logic [CP_W-1:0] CP_RI_LO     = 21'h1F1E6;
    localparam logic [CP_W-1:0] CP_RI_HI     = 21'h1F1FF;

    typedef struct packed {
        logic [15:0]        text_offset;
        logic [15:0]        glyph_length;
        logic [15:0]        text_length;
        logic [15:0]        codepoint_end;
        logic [7:0]         lead_byte;
        logic [7:0]         second_byte;
        logic [7:0]         third_byte;
        logic [7:0]         fourth_byte;
        logic signed [31:0] advance;
        logic               last_glyph;
    } glyph_t;

    typedef struct packed {
        logic [15:0]        column_index;
        logic [15:0]        start_byte;
        logic [15:0]        stop_byte;
        logic [15:0]        start_glyph;
        logic [16:0]        stop_glyph;
        logic signed [31:0] total_advance;
        logic signed [31:0] scaled_advance;
        logic               last_column;
    } column_t;

    // Decoded glyph, registered between decode and accumulate.
    typedef struct packed {
        logic [15:0]              start_byte;
        logic [15:0]              stop_byte;
        logic signed [31:0]       advance;
        logic signed [TERM_W-1:0] term;
        logic                     zwj;
        logic                     mark;
        logic                     ri;
        logic                     last_glyph;
    } glyph_info_t;

    typedef struct packed {
        logic       pending_valid;
        logic [1:0] count;
    } accum_status_t;

endpackage

>>> design/gcs_decode.sv
module gcs_decode (
    input  gcs_pkg::glyph_t      glyph,
    input  logic [15:0]          scale,
    output gcs_pkg::glyph_info_t info
);
    import gcs_pkg::*;

    function automatic logic in_span(input logic [CP_W-1:0] v,
                                     input logic [CP_W-1:0] lo,
                                     input logic [CP_W-1:0] hi);
        in_span = (v >= lo) && (v <= hi);
    endfunction

    logic                past_end;
    logic [16:0]         span;
    logic [16:0]         end_sum;
    logic [CP_W-1:0]     cp;
    logic [5:0]          b1;
    logic [5:0]          b2;
    logic [5:0]          b3;
    logic signed [48:0]  prod;

    assign past_end = glyph.text_offset >= glyph.text_length;
    assign span     = {1'b0, glyph.codepoint_end} - {1'b0, glyph.text_offset};
    assign b1       = glyph.second_byte[5:0];
    assign b2       = glyph.third_byte[5:0];
    assign b3       = glyph.fourth_byte[5:0];

    always_comb
    begin
        if (past_end)
        begin
            cp = '0;
        end
        else if (glyph.lead_byte < ASCII_LIMIT || glyph.codepoint_end < glyph.text_offset)
        begin
            cp = CP_W'(glyph.lead_byte);
        end
        else if (span == 17'd2)
        begin
            cp = CP_W'({glyph.lead_byte[4:0], b1});
        end
        else if (span == 17'd3)
        begin
            cp = CP_W'({glyph.lead_byte[3:0], b1, b2});
        end
        else if (span == 17'd4)
        begin
            cp = {glyph.lead_byte[2:0], b1, b2, b3};
        end
        else
        begin
            cp = CP_W'(glyph.lead_byte);
        end
    end

    // round half up, then floor by the scale's fraction
    assign prod    = glyph.advance * $signed({1'b0, scale}) + 49'sd128;
    assign end_sum = {1'b0, glyph.text_offset} + {1'b0, glyph.glyph_length};

    always_comb
    begin
        info.start_byte = past_end ? glyph.text_length : glyph.text_offset;
        info.stop_byte  = (end_sum < {1'b0, glyph.text_length}) ? end_sum[15:0]
                                                                : glyph.text_length;
        info.advance    = glyph.advance;
        info.term       = prod[48:SCALE_FRAC];
        info.zwj        = cp == CP_ZWJ;
        info.mark       = in_span(cp, CP_COMB_A_LO, CP_COMB_A_HI)
                       || in_span(cp, CP_COMB_B_LO, CP_COMB_B_HI)
                       || in_span(cp, CP_COMB_C_LO, CP_COMB_C_HI)
                       || in_span(cp, CP_COMB_D_LO, CP_COMB_D_HI)
                       || in_span(cp, CP_COMB_E_LO, CP_COMB_E_HI)
                       || in_span(cp, CP_VS_A_LO, CP_VS_A_HI)
                       || in_span(cp, CP_VS_B_LO, CP_VS_B_HI);
        info.ri         = in_span(cp, CP_RI_LO, CP_RI_HI);
        info.last_glyph = glyph.last_glyph;
    end

endmodule

>>> design/gcs_accum.sv
module gcs_accum (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  gcs_pkg::glyph_info_t   info,
    output gcs_pkg::column_t       first,
    output gcs_pkg::column_t       second,
    output gcs_pkg::accum_status_t status
);
    import gcs_pkg::*;

    logic                    pend_valid_reg, pend_valid_next;
    logic [15:0]             pend_bs_reg, pend_bs_next;
    logic [15:0]             pend_be_reg, pend_be_next;
    logic [15:0]             pend_gs_reg, pend_gs_next;
    logic signed [31:0]      pend_adv_reg, pend_adv_next;
    logic signed [31:0]      pend_dev_reg, pend_dev_next;
    logic [1:0]              ind_cnt_reg, ind_cnt_next;
    logic                    after_zwj_reg, after_zwj_next;
    logic [INDEX_BITS:0]     glyph_cnt_reg, glyph_cnt_next;
    logic [INDEX_BITS-1:0]   col_cnt_reg, col_cnt_next;

    logic                    joins;
    logic                    closes;
    logic signed [31:0]      adv_base;
    logic signed [31:0]      dev_base;
    logic signed [32:0]      adv_sum;
    logic signed [41:0]      dev_sum;
    logic signed [31:0]      adv_new;
    logic signed [31:0]      dev_new;
    logic [15:0]             bs_new;
    logic [15:0]             gs_new;
    logic [1:0]              ind_new;
    logic [INDEX_BITS:0]     gc_new;
    logic [INDEX_BITS-1:0]   cc_new;
    column_t                 closed;
    column_t                 finished;

    always_comb
    begin
        joins  = pend_valid_reg && (info.zwj || info.mark || after_zwj_reg
                                    || (ind_cnt_reg == 2'd1 && info.ri));
        closes = pend_valid_reg && !joins;

        closed.column_index   = 16'(col_cnt_reg);
        closed.start_byte     = pend_bs_reg;
        closed.stop_byte      = pend_be_reg;
        closed.start_glyph    = pend_gs_reg;
        closed.stop_glyph     = 17'(glyph_cnt_reg);
        closed.total_advance  = pend_adv_reg;
        closed.scaled_advance = pend_dev_reg;
        closed.last_column    = 1'b0;

        adv_base = joins ? pend_adv_reg : 32'sd0;
        dev_base = joins ? pend_dev_reg : 32'sd0;
        adv_sum  = {adv_base[31], adv_base} + {info.advance[31], info.advance};
        dev_sum  = 42'(dev_base) + 42'(info.term);

        // saturate to the signed 32-bit range
        if (adv_sum[32] != adv_sum[31])
        begin
            adv_new = adv_sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        else
        begin
            adv_new = adv_sum[31:0];
        end
        if (dev_sum[41:31] != {11{dev_sum[41]}})
        begin
            dev_new = dev_sum[41] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        else
        begin
            dev_new = dev_sum[31:0];
        end

        bs_new = joins ? pend_bs_reg : info.start_byte;
        gs_new = joins ? pend_gs_reg : 16'(glyph_cnt_reg);
        gc_new = glyph_cnt_reg + (INDEX_BITS+1)'(1);
        cc_new = closes ? col_cnt_reg + INDEX_BITS'(1) : col_cnt_reg;

        if (!joins)
        begin
            ind_new = info.ri ? 2'd1 : 2'd0;
        end
        else if (!info.zwj && info.ri && ind_cnt_reg < 2'd2)
        begin
            ind_new = ind_cnt_reg + 2'd1;
        end
        else
        begin
            ind_new = ind_cnt_reg;
        end

        finished.column_index   = 16'(cc_new);
        finished.start_byte     = bs_new;
        finished.stop_byte      = info.stop_byte;
        finished.start_glyph    = gs_new;
        finished.stop_glyph     = 17'(gc_new);
        finished.total_advance  = adv_new;
        finished.scaled_advance = dev_new;
        finished.last_column    = 1'b1;

        first  = closes ? closed : finished;
        second = finished;
        status.pending_valid = pend_valid_reg;
        status.count         = {1'b0, closes} + {1'b0, info.last_glyph};

        if (info.last_glyph)
        begin
            // end of run: drop all run state
            pend_valid_next = 1'b0;
            pend_bs_next    = '0;
            pend_be_next    = '0;
            pend_gs_next    = '0;
            pend_adv_next   = '0;
            pend_dev_next   = '0;
            ind_cnt_next    = '0;
            after_zwj_next  = 1'b0;
            glyph_cnt_next  = '0;
            col_cnt_next    = '0;
        end
        else
        begin
            pend_valid_next = 1'b1;
            pend_bs_next    = bs_new;
            pend_be_next    = info.stop_byte;
            pend_gs_next    = gs_new;
            pend_adv_next   = adv_new;
            pend_dev_next   = dev_new;
            ind_cnt_next    = ind_new;
            after_zwj_next  = joins && info.zwj;
            glyph_cnt_next  = gc_new;
            col_cnt_next    = cc_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_bs_reg    <= '0;
            pend_be_reg    <= '0;
            pend_gs_reg    <= '0;
            pend_adv_reg   <= '0;
            pend_dev_reg   <= '0;
            ind_cnt_reg    <= '0;
            after_zwj_reg  <= 1'b0;
            glyph_cnt_reg  <= '0;
            col_cnt_reg    <= '0;
        end
        else if (fire)
        begin
            pend_valid_reg <= pend_valid_next;
            pend_bs_reg    <= pend_bs_next;
            pend_be_reg    <= pend_be_next;
            pend_gs_reg    <= pend_gs_next;
            pend_adv_reg   <= pend_adv_next;
            pend_dev_reg   <= pend_dev_next;
            ind_cnt_reg    <= ind_cnt_next;
            after_zwj_reg  <= after_zwj_next;
            glyph_cnt_reg  <= glyph_cnt_next;
            col_cnt_reg    <= col_cnt_next;
        end
    end

endmodule

>>> design/gcs_out_fifo.sv
module gcs_out_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       wr_cnt,
    input  gcs_pkg::column_t wr_first,
    input  gcs_pkg::column_t wr_second,
    input  logic             pop,
    output gcs_pkg::column_t head,
    output logic [2:0]       count
);
    import gcs_pkg::*;

    column_t    mem_reg [FIFO_DEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic [1:0] wr_ptr_plus;

    assign wr_ptr_plus = wr_ptr_reg + 2'd1;
    assign wr_ptr_next = wr_ptr_reg + wr_cnt;
    assign rd_ptr_next = rd_ptr_reg + {1'b0, pop};
    assign count_next  = count_reg + {1'b0, wr_cnt} - {2'b00, pop};
    assign head        = mem_reg[rd_ptr_reg];
    assign count       = count_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < FIFO_DEPTH; i++)
        begin
            if (wr_cnt != 2'd0 && wr_ptr_reg == 2'(i))
            begin
                mem_reg[i] <= wr_first;
            end
            else if (wr_cnt == 2'd2 && wr_ptr_plus == 2'(i))
            begin
                mem_reg[i] <= wr_second;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> design/grapheme_column_segmenter_top.sv
// Channel   Direction  Handshake                    Payload
// glyph     in         glyph_valid / glyph_ready    glyph  (gcs_pkg::glyph_t)
// column    out        column_valid / column_ready  column (gcs_pkg::column_t)
// scale     in         scale_valid / scale_ready    scale_data (8.8 unsigned)
//
// One glyph transaction per cycle while column_ready holds and glyphs average at most one column.
// A glyph's columns reach the column port through the input register, the decode
// register, then the output queue, and can be taken once they sit in the queue.
// A glyph that closes a column and ends the run yields two column
// transactions, so the single-read output queue sets the long-run rate.
// Reset clears the run state and loads scale with 1.0; queue payload is not reset.
// Output stalls back up through the queue into the two register stages.
`include "assert_macros.svh"

module grapheme_column_segmenter_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             glyph_valid,
    output logic             glyph_ready,
    input  gcs_pkg::glyph_t  glyph,
    output logic             column_valid,
    input  logic             column_ready,
    output gcs_pkg::column_t column,
    input  logic             scale_valid,
    output logic             scale_ready,
    input  logic [15:0]      scale_data
);
    import gcs_pkg::*;

    logic          scale_write;
    logic [15:0]   scale_val_reg;
    logic          a_valid_reg, a_valid_next;
    glyph_t        a_reg;
    logic          b_valid_reg, b_valid_next;
    glyph_info_t   b_reg;
    glyph_info_t   dec_info;
    logic          a_load;
    logic          b_load;
    logic          b_fire;
    logic          pop;
    logic [1:0]    wr_cnt;
    logic [2:0]    fifo_count;
    column_t       acc_first;
    column_t       acc_second;
    accum_status_t acc_status;
    logic          run_end;
    logic          pair_write;
    logic [2:0]    fifo_count_calc;

    // The user must make scale writes only while the block is idle; it is not enforced: always take them.
    assign scale_ready = 1'b1;
    assign scale_write = scale_valid && scale_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_val_reg <= SCALE_RESET;
        end
        else if (scale_write)
        begin
            scale_val_reg <= scale_data;
        end
    end

    // Advance the accumulate stage only when the queue can absorb two columns.
    assign b_fire       = b_valid_reg && (fifo_count <= 3'(FIFO_DEPTH - 2));
    assign b_load       = a_valid_reg && (!b_valid_reg || b_fire);
    assign glyph_ready  = !a_valid_reg || b_load;
    assign a_load       = glyph_valid && glyph_ready;
    assign a_valid_next = a_load ? 1'b1 : (b_load ? 1'b0 : a_valid_reg);
    assign b_valid_next = b_load ? 1'b1 : (b_fire ? 1'b0 : b_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // Hold payload in place while stalled.
    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_reg <= glyph;
        end
        if (b_load)
        begin
            b_reg <= dec_info;
        end
    end

    // Decode codepoint, classify, form byte span and scaled advance term.
    gcs_decode u_decode (
        .glyph (a_reg),
        .scale (scale_val_reg),
        .info  (dec_info)
    );

    // Join or close columns and accumulate saturating advances.
    gcs_accum u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (b_fire),
        .info   (b_reg),
        .first  (acc_first),
        .second (acc_second),
        .status (acc_status)
    );

    assign wr_cnt = b_fire ? acc_status.count : 2'd0;
    assign pop    = column_valid && column_ready;

    // Result queue decouples column stalls from glyph intake.
    gcs_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_cnt    (wr_cnt),
        .wr_first  (acc_first),
        .wr_second (acc_second),
        .pop       (pop),
        .head      (column),
        .count     (fifo_count)
    );

    assign column_valid = fifo_count != 3'd0;

    assign run_end         = b_fire && b_reg.last_glyph;
    assign pair_write      = b_fire && acc_status.count == 2'd2;
    assign fifo_count_calc = fifo_count + {1'b0, wr_cnt} - {2'b00, pop};

    `ASSERT_NEXT(a_run_clear, clk, rst_n, run_end, !acc_status.pending_valid)
    `ASSERT_IMP(a_pair_order, clk, rst_n, pair_write, !acc_first.last_column && acc_second.last_column)
    `ASSERT_NEXT(a_fifo_count, clk, rst_n, 1'b1, fifo_count == $past(fifo_count_calc))

endmodule

>>> test/grapheme_column_scoreboard.sv
`timescale 1ns / 100ps

module grapheme_column_scoreboard (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             glyph_valid,
    input  logic             glyph_ready,
    input  gcs_pkg::glyph_t  glyph,
    input  logic             column_valid,
    input  logic             column_ready,
    input  gcs_pkg::column_t column,
    input  logic             scale_valid,
    input  logic             scale_ready,
    input  logic [15:0]      scale_data,
    output int               mismatches,
    output int               columns_owed
);
    import gcs_pkg::*;

    localparam longint SUM_MAX = 2147483647;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    column_t expected_columns[$];

    logic [15:0]     scale_reg;
    logic            col_open;
    logic [15:0]     col_byte_first;
    logic [15:0]     col_byte_stop;
    logic [16:0]     col_glyph_first;
    longint          col_total;
    longint          col_device;
    logic [1:0]      ri_seen;
    logic            after_zwj;
    logic [16:0]     glyphs_seen;
    logic [15:0]     columns_done;

    initial mismatches = 0;

    function automatic longint sat32(input longint v);
        if (v > SUM_MAX)
        begin
            return SUM_MAX;
        end
        if (v < SUM_MIN)
        begin
            return SUM_MIN;
        end
        return v;
    endfunction

    function automatic logic [CP_W-1:0] decode_codepoint(input glyph_t g);
        logic [15:0] span;
        if (g.text_offset >= g.text_length)
        begin
            return '0;
        end
        if (g.lead_byte < ASCII_LIMIT || g.codepoint_end < g.text_offset)
        begin
            return CP_W'(g.lead_byte);
        end
        span = g.codepoint_end - g.text_offset;
        case (span)
            16'd2: return {10'b0, g.lead_byte[4:0], g.second_byte[5:0]};
            16'd3: return {5'b0, g.lead_byte[3:0], g.second_byte[5:0], g.third_byte[5:0]};
            16'd4: return {g.lead_byte[2:0], g.second_byte[5:0], g.third_byte[5:0],
                           g.fourth_byte[5:0]};
            default: return CP_W'(g.lead_byte);
        endcase
    endfunction

    // Combining marks and variation selectors always attach to the open column.
    function automatic logic is_attaching(input logic [CP_W-1:0] cp);
        return (cp >= CP_COMB_A_LO && cp <= CP_COMB_A_HI) ||
               (cp >= CP_COMB_B_LO && cp <= CP_COMB_B_HI) ||
               (cp >= CP_COMB_C_LO && cp <= CP_COMB_C_HI) ||
               (cp >= CP_COMB_D_LO && cp <= CP_COMB_D_HI) ||
               (cp >= CP_COMB_E_LO && cp <= CP_COMB_E_HI) ||
               (cp >= CP_VS_A_LO && cp <= CP_VS_A_HI) ||
               (cp >= CP_VS_B_LO && cp <= CP_VS_B_HI);
    endfunction

    function automatic column_t close_column(input logic is_last);
        column_t c;
        c.column_index   = columns_done;
        c.start_byte     = col_byte_first;
        c.stop_byte      = col_byte_stop;
        c.start_glyph    = col_glyph_first[15:0];
        c.stop_glyph     = glyphs_seen;
        c.total_advance  = col_total[31:0];
        c.scaled_advance = col_device[31:0];
        c.last_column    = is_last;
        return c;
    endfunction

    task automatic clear_run();
        col_open        = 1'b0;
        col_byte_first  = '0;
        col_byte_stop   = '0;
        col_glyph_first = '0;
        col_total       = 0;
        col_device      = 0;
        ri_seen         = '0;
        after_zwj       = 1'b0;
        glyphs_seen     = '0;
        columns_done    = '0;
    endtask

    task automatic add_glyph(input glyph_t g);
        logic [16:0] span_end;
        longint      adv;
        longint      scaled;
        span_end = {1'b0, g.text_offset} + {1'b0, g.glyph_length};
        col_byte_stop = (span_end < {1'b0, g.text_length}) ? span_end[15:0] : g.text_length;
        adv = longint'($signed(g.advance));
        // Round half up: add one half LSB, then floor.
        scaled = (adv * longint'(scale_reg) + (longint'(1) << (SCALE_FRAC - 1))) >>> SCALE_FRAC;
        col_total   = sat32(col_total + adv);
        col_device  = sat32(col_device + scaled);
        glyphs_seen = glyphs_seen + 17'd1;
    endtask

    task automatic segment_glyph(input glyph_t g);
        logic [CP_W-1:0] cp;
        logic            zwj;
        logic            ri;
        logic            joins;
        cp    = decode_codepoint(g);
        zwj   = (cp == CP_ZWJ);
        ri    = (cp >= CP_RI_LO && cp <= CP_RI_HI);
        joins = col_open && (zwj || is_attaching(cp) || after_zwj || (ri_seen == 2'd1 && ri));
        if (joins)
        begin
            add_glyph(g);
            if (zwj)
            begin
                after_zwj = 1'b1;
            end
            else
            begin
                after_zwj = 1'b0;
                if (ri && ri_seen < 2'd2)
                begin
                    ri_seen = ri_seen + 2'd1;
                end
            end
        end
        else
        begin
            if (col_open)
            begin
                expected_columns = {expected_columns, close_column(1'b0)};
                columns_done = columns_done + 16'd1;
            end
            col_open        = 1'b1;
            col_byte_first  = (g.text_offset >= g.text_length) ? g.text_length : g.text_offset;
            col_glyph_first = glyphs_seen;
            col_total       = 0;
            col_device      = 0;
            ri_seen         = ri ? 2'd1 : 2'd0;
            after_zwj       = 1'b0;
            add_glyph(g);
        end
        if (g.last_glyph)
        begin
            expected_columns = {expected_columns, close_column(1'b1)};
            clear_run();
        end
    endtask

    task automatic check_field(input string label, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
            mismatches = mismatches + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        column_t want;
        if (!rst_n)
        begin
            scale_reg = SCALE_RESET;
            clear_run();
            expected_columns.delete();
        end
        else
        begin
            if (scale_valid && scale_ready)
            begin
                scale_reg = scale_data;
            end
            if (column_valid && column_ready)
            begin
                if (expected_columns.size() == 0)
                begin
                    $display("%0t: unexpected column, expected none, actual %h", $time, column);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = expected_columns.pop_front();
                    check_field("column_index", want.column_index, column.column_index);
                    check_field("start_byte", want.start_byte, column.start_byte);
                    check_field("stop_byte", want.stop_byte, column.stop_byte);
                    check_field("start_glyph", want.start_glyph, column.start_glyph);
                    check_field("stop_glyph", want.stop_glyph, column.stop_glyph);
                    check_field("total_advance", want.total_advance, column.total_advance);
                    check_field("scaled_advance", want.scaled_advance, column.scaled_advance);
                    check_field("last_column", want.last_column, column.last_column);
                end
            end
            if (glyph_valid && glyph_ready)
            begin
                segment_glyph(glyph);
            end
        end
        columns_owed = expected_columns.size();
    end

endmodule

>>> test/grapheme_column_segmenter_top_tb.sv
`timescale 1ns / 100ps

module grapheme_column_segmenter_top_tb;
    import gcs_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 6;
    // Covers the register stages plus the output queue; give it some margin.
    localparam int DRAIN_CYCLES   = 16;
    // Long enough to fill both register stages and the output queue many times over.
    localparam int HOLD_CYCLES    = 400;
    // Longest quiet stretch in a correct run is the receiver hold-off above.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 280;
    localparam int NUM_PHASES     = 6;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        glyph_valid  = 1'b0;
    glyph_t      glyph        = '0;
    logic        column_ready = 1'b0;
    logic        scale_valid  = 1'b0;
    logic [15:0] scale_data   = '0;
    logic        glyph_ready;
    logic        column_valid;
    column_t     column;
    logic        scale_ready;

    int mismatches;
    int columns_owed;

    // Per-cycle idle odds, in percent, for the sender and the receiver.
    int src_idle_pct  = 0;
    int dst_idle_pct  = 0;
    // The stimulus asks for a hold-off by bumping hold_requests; the receiver
    // process owns holds_done and catches up once the hold is over.
    int hold_requests = 0;
    int holds_done    = 0;
    int quiet_cycles  = 0;

    grapheme_column_segmenter_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .glyph_valid  (glyph_valid),
        .glyph_ready  (glyph_ready),
        .glyph        (glyph),
        .column_valid (column_valid),
        .column_ready (column_ready),
        .column       (column),
        .scale_valid  (scale_valid),
        .scale_ready  (scale_ready),
        .scale_data   (scale_data)
    );

    grapheme_column_scoreboard scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .glyph_valid  (glyph_valid),
        .glyph_ready  (glyph_ready),
        .glyph        (glyph),
        .column_valid (column_valid),
        .column_ready (column_ready),
        .column       (column),
        .scale_valid  (scale_valid),
        .scale_ready  (scale_ready),
        .scale_data   (scale_data),
        .mismatches   (mismatches),
        .columns_owed (columns_owed)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Receiver: drive ready at the falling edge. A pending hold request drops
    // ready for a long stretch so the block backs up into its input.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (holds_done != hold_requests)
            begin
                column_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                holds_done = holds_done + 1;
            end
            else
            begin
                column_ready <= ($urandom_range(99) >= dst_idle_pct);
            end
        end
    end

    // Watchdog: count cycles with no transaction on any channel.
    always @(posedge clk)
    begin
        if (!rst_n || (glyph_valid && glyph_ready) || (column_valid && column_ready) ||
            (scale_valid && scale_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Build a well-formed UTF-8 glyph for one codepoint; trailing bytes past
    // the encoding are just whatever text follows, so fill them at random.
    function automatic glyph_t cp_glyph(input logic [CP_W-1:0] cp, input logic [15:0] off,
                                        input logic [15:0] tlen, input logic signed [31:0] adv,
                                        input logic is_last);
        glyph_t      g;
        logic [15:0] span;
        g.text_offset = off;
        g.text_length = tlen;
        g.advance     = adv;
        g.last_glyph  = is_last;
        g.second_byte = 8'($urandom);
        g.third_byte  = 8'($urandom);
        g.fourth_byte = 8'($urandom);
        if (cp < 21'h80)
        begin
            g.lead_byte = cp[7:0];
            span = 16'd1;
        end
        else if (cp < 21'h800)
        begin
            g.lead_byte   = {3'b110, cp[10:6]};
            g.second_byte = {2'b10, cp[5:0]};
            span = 16'd2;
        end
        else if (cp < 21'h10000)
        begin
            g.lead_byte   = {4'b1110, cp[15:12]};
            g.second_byte = {2'b10, cp[11:6]};
            g.third_byte  = {2'b10, cp[5:0]};
            span = 16'd3;
        end
        else
        begin
            g.lead_byte   = {5'b11110, cp[20:18]};
            g.second_byte = {2'b10, cp[17:12]};
            g.third_byte  = {2'b10, cp[11:6]};
            g.fourth_byte = {2'b10, cp[5:0]};
            span = 16'd4;
        end
        g.glyph_length  = span;
        g.codepoint_end = off + span;
        return g;
    endfunction

    // Offer one glyph at the falling edge and hold it until accepted. Valid
    // stays high into the next call, which lowers it only when it idles.
    task automatic send_glyph(input glyph_t g);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            glyph_valid <= 1'b0;
            @(negedge clk);
        end
        glyph       <= g;
        glyph_valid <= 1'b1;
        @(posedge clk);
        while (!glyph_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_scale(input logic [15:0] value);
        scale_data  <= value;
        scale_valid <= 1'b1;
        @(posedge clk);
        while (!scale_ready) @(posedge clk);
        @(negedge clk);
        scale_valid <= 1'b0;
    endtask

    // Drop valid, wait until every expected column is out, then let glyphs
    // that close nothing clear the pipeline too.
    task automatic settle();
        glyph_valid <= 1'b0;
        @(negedge clk);
        while (columns_owed != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Random runs: mostly well-formed text with a mix of marks, joiners and
    // flag pairs, sprinkled with raw noise glyphs and unterminated runs.
    task automatic run_random(input int count);
        int                 sent;
        int                 run_len;
        int                 k;
        int                 pick;
        logic               heavy;
        logic               is_last;
        logic [15:0]        pos;
        logic [15:0]        tlen;
        logic [CP_W-1:0]    cp;
        logic [CP_W-1:0]    lo;
        logic [CP_W-1:0]    hi;
        logic signed [31:0] adv;
        glyph_t             g;
        sent = 0;
        while (sent < count)
        begin
            run_len = $urandom_range(1, 12);
            pos     = ($urandom_range(99) < 10) ? 16'($urandom) : 16'($urandom_range(0, 255));
            tlen    = pos + 16'($urandom_range(0, 4 * run_len + 6));
            heavy   = ($urandom_range(9) == 0);
            for (k = 0; k < run_len; k++)
            begin
                is_last = (k == run_len - 1) && ($urandom_range(19) != 0);
                pick    = $urandom_range(99);
                if (heavy)
                begin
                    adv = $urandom;
                end
                else
                begin
                    case ($urandom_range(19))
                        0:       adv = $urandom;
                        1, 2:    adv = '0;
                        3, 4, 5: adv = -$urandom_range(0, 32'h0008_0000);
                        default: adv = $urandom_range(0, 32'h0028_0000);
                    endcase
                end
                if (pick < 10)
                begin
                    // Noise: raw fields, half of them anchored to the run.
                    g = {$urandom, $urandom, $urandom, $urandom, 1'b0};
                    g.last_glyph = ($urandom_range(9) == 0);
                    if ($urandom_range(1))
                    begin
                        g.text_offset   = pos;
                        g.text_length   = tlen;
                        g.codepoint_end = pos + 16'($urandom_range(0, 5));
                    end
                    pos = pos + 16'd1;
                end
                else
                begin
                    if (pick < 36)
                    begin
                        cp = CP_W'($urandom_range(0, 127));
                    end
                    else if (pick < 44)
                    begin
                        cp = CP_W'($urandom_range(128, 2047));
                    end
                    else if (pick < 48)
                    begin
                        cp = CP_W'($urandom_range(21'h800, 21'hFFFF));
                    end
                    else if (pick < 56)
                    begin
                        cp = CP_ZWJ;
                    end
                    else if (pick < 66)
                    begin
                        cp = CP_W'($urandom_range(CP_RI_LO, CP_RI_HI));
                    end
                    else if (pick < 74)
                    begin
                        cp = CP_W'($urandom_range(21'h1F300, 21'h1FAFF));
                    end
                    else
                    begin
                        case ($urandom_range(7))
                            0: begin lo = CP_COMB_A_LO; hi = CP_COMB_A_HI; end
                            1: begin lo = CP_COMB_B_LO; hi = CP_COMB_B_HI; end
                            2: begin lo = CP_COMB_C_LO; hi = CP_COMB_C_HI; end
                            3: begin lo = CP_COMB_D_LO; hi = CP_COMB_D_HI; end
                            4: begin lo = CP_COMB_E_LO; hi = CP_COMB_E_HI; end
                            5: begin lo = CP_VS_A_LO; hi = CP_VS_A_HI; end
                            6: begin lo = CP_VS_B_LO; hi = CP_VS_B_HI; end
                            default: begin lo = CP_RI_LO; hi = CP_RI_HI; end
                        endcase
                        // A quarter of the time land on or just beside a range bound.
                        if ($urandom_range(3) == 0)
                        begin
                            case ($urandom_range(3))
                                0:       cp = lo - 1'b1;
                                1:       cp = lo;
                                2:       cp = hi;
                                default: cp = hi + 1'b1;
                            endcase
                        end
                        else
                        begin
                            cp = CP_W'($urandom_range(lo, hi));
                        end
                    end
                    g = cp_glyph(cp, pos, tlen, adv, is_last);
                    if ($urandom_range(9) == 0)
                    begin
                        g.glyph_length = 16'($urandom_range(0, 8));
                    end
                    pos = g.codepoint_end;
                end
                send_glyph(g);
                sent++;
            end
        end
    endtask

    initial
    begin
        glyph_t      g;
        logic [15:0] next_scale;
        int          p;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed glyphs at the reset scale of 1.0, no idling.
        send_glyph(cp_glyph(21'h41, 16'd0, 16'd40, 32'sh0001_0000, 1'b0));
        // A combining mark and a joiner attach; the emoji after the joiner attaches too.
        send_glyph(cp_glyph(21'h301, 16'd1, 16'd40, 32'sh0000_8000, 1'b0));
        send_glyph(cp_glyph(CP_ZWJ, 16'd3, 16'd40, 32'sh0000_0000, 1'b0));
        send_glyph(cp_glyph(21'h1F600, 16'd6, 16'd40, 32'sh0002_0000, 1'b0));
        // Flag pair joins; a third indicator opens a new column.
        send_glyph(cp_glyph(CP_RI_LO, 16'd10, 16'd40, 32'sh0001_8000, 1'b0));
        send_glyph(cp_glyph(CP_RI_HI, 16'd14, 16'd40, 32'sh0001_8000, 1'b0));
        send_glyph(cp_glyph(CP_RI_LO + 1'b1, 16'd18, 16'd40, 32'sh0000_0081, 1'b0));
        send_glyph(cp_glyph(CP_VS_A_HI, 16'd22, 16'd40, 32'sh0000_007F, 1'b0));
        send_glyph(cp_glyph(CP_VS_B_LO, 16'd25, 16'd40, -32'sd129, 1'b0));
        // End of run after a column is open: closes both.
        send_glyph(cp_glyph(21'h7F, 16'd29, 16'd40, -32'sd1, 1'b1));
        // A joiner that opens a column does not pull in the next glyph.
        send_glyph(cp_glyph(CP_ZWJ, 16'd0, 16'd40, 32'sh0000_4000, 1'b0));
        send_glyph(cp_glyph(21'h62, 16'd3, 16'd40, 32'sh0000_C000, 1'b0));
        // Bad span: decodes as the lead byte.
        g = cp_glyph(21'h2010, 16'd4, 16'd40, 32'sh0001_0000, 1'b0);
        g.codepoint_end = 16'd5;
        send_glyph(g);
        // Span end below the offset.
        g = cp_glyph(CP_COMB_A_HI, 16'd10, 16'd40, 32'sh0001_0000, 1'b0);
        g.codepoint_end = 16'd5;
        send_glyph(g);
        // Continuation byte as lead with a two-byte span.
        g = cp_glyph(21'h41, 16'd12, 16'd40, 32'sh0000_0100, 1'b0);
        g.lead_byte     = 8'h80;
        g.codepoint_end = 16'd14;
        send_glyph(g);
        // Offset past the end of the text: codepoint zero, start clamps.
        send_glyph(cp_glyph(CP_COMB_B_LO, 16'd50, 16'd40, 32'sh0001_0000, 1'b0));
        // Saturation both ways within one column.
        send_glyph(cp_glyph(21'h41, 16'd12, 16'd40, 32'sh7FFF_FFFF, 1'b0));
        send_glyph(cp_glyph(CP_COMB_C_LO, 16'd13, 16'd40, 32'sh7FFF_FFFF, 1'b0));
        send_glyph(cp_glyph(CP_COMB_D_HI, 16'd15, 16'd40, 32'sh8000_0000, 1'b0));
        send_glyph(cp_glyph(CP_COMB_E_LO, 16'd18, 16'd40, 32'sh8000_0000, 1'b0));
        // Field extremes: offset equal to text length, then an unwrapped end.
        g = cp_glyph(21'h41, 16'hFFFF, 16'hFFFF, 32'sh7FFF_FFFF, 1'b0);
        g.glyph_length = 16'hFFFF;
        send_glyph(g);
        g = cp_glyph(21'h7A, 16'hFFFE, 16'hFFFF, 32'sh8000_0000, 1'b1);
        g.glyph_length = 16'hFFFF;
        send_glyph(g);

        // Random phases: new scale written while idle, then a batch of runs.
        for (p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            case (p)
                0: begin next_scale = 16'hFFFF;         src_idle_pct = 0;  dst_idle_pct = 0;  end
                1: begin next_scale = 16'h0000;         src_idle_pct = 73; dst_idle_pct = 0;  end
                2: begin next_scale = 16'($urandom);    src_idle_pct = 0;  dst_idle_pct = 73; end
                3: begin next_scale = 16'd128;          src_idle_pct = 20; dst_idle_pct = 20; end
                4: begin next_scale = SCALE_RESET;      src_idle_pct = 0;  dst_idle_pct = 0;  end
                default: begin next_scale = 16'($urandom); src_idle_pct = 20; dst_idle_pct = 20; end
            endcase
            write_scale(next_scale);
            // Hold the receiver off while the sender keeps pushing.
            if (p == 2 || p == 4)
            begin
                hold_requests = hold_requests + 1;
            end
            run_random(PHASE_ITEMS);
        end

        settle();
        if (mismatches == 0 && columns_owed == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
